FILE: rtl/wsts_pkg.sv
// ----------------------------------------------------------------------------
// wsts_pkg
// shared types and constants of the wav stream to stereo sample decoder
// ----------------------------------------------------------------------------
package wsts_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [4:0]  FMT_BODY = 5'd16;

    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_FRAME  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [15:0] CODE_FLOAT = 16'd3;

    // how one sample lane is turned into a single-precision pattern
    typedef enum logic [2:0] {
        CV_ZERO,
        CV_PASS,
        CV_16,
        CV_24,
        CV_32
    } t_conv;

    // one result request from the parser
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] left_raw;
        logic [31:0] right_raw;
        t_conv       mode;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] bits_each;
    } t_req;

endpackage

FILE: rtl/wav_stream_to_stereo_samples.sv
// ----------------------------------------------------------------------------
// wav_stream_to_stereo_samples
// wav file byte stream in, format report / stereo float frames out
// ----------------------------------------------------------------------------
// usage
//   slave side: one file byte per word on s_axis tdata, tlast on the final
//   byte of the file; after that byte the parser starts over at the riff tag
//   master side: one result word per format report, stereo frame or header
//   error; tuser holds the kind, tdata holds samples and fmt values
// path: a word that causes a result goes through the parser register (loaded on
//   the accepting edge), then two lane stages and the output register
// throughput: one byte per cycle while the skid register is empty, set by the
//   single-pass parser register and the fully pipelined sample lanes
// stall: an output register plus a skid register; ready on the slave side
//   is low while the skid register holds a word and the whole pipeline
//   holds until the receiver takes a word
// reset: synchronous, active low; parser back to the riff tag, all pipeline
//   and output valids cleared
// ----------------------------------------------------------------------------
module wav_stream_to_stereo_samples (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // byte_value
    input  logic         i_s_axis_tlast,   // stream_end
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // left_sample, right_sample, format_tag, channel_count, rate_hz, bits_each
    output logic [143:0] o_m_axis_tdata,
    output logic [1:0]   o_m_axis_tuser    // result_kind
);
    import wsts_pkg::*;

    logic        en;
    logic        req_valid;
    t_req        req;
    logic [31:0] left_single, right_single;

    // side fields ride alongside the lane stages
    logic        r1_valid, r2_valid;
    logic [1:0]  r1_kind, r2_kind;
    logic [79:0] r1_fmt, r2_fmt;

    logic [143:0] new_data;
    logic [143:0] r_out_data, r_skid_data;
    logic [1:0]   r_out_kind, r_skid_kind;
    logic         r_out_valid, r_skid_valid;

    // pipeline moves while the skid slot is free
    assign en = !r_skid_valid;
    assign o_s_axis_tready = en;

    wsts_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_s_axis_tvalid),
        .i_byte      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .o_req_valid (req_valid),
        .o_req       (req)
    );

    wsts_conv u_left (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_raw    (req.left_raw),
        .i_mode   (req.mode),
        .o_single (left_single)
    );

    wsts_conv u_right (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_raw    (req.right_raw),
        .i_mode   (req.mode),
        .o_single (right_single)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= req_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_kind <= req.kind;
            r1_fmt  <= {req.bits_each, req.rate_hz, req.channel_count, req.format_tag};
            r2_kind <= r1_kind;
            r2_fmt  <= r1_fmt;
        end
    end

    assign new_data = {r2_fmt, right_single, left_single};

    // output register with skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (en && r2_valid) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_out_valid && i_m_axis_tready) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r2_valid) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out_data <= new_data;
                r_out_kind <= r2_kind;
            end else begin
                r_skid_data <= new_data;
                r_skid_kind <= r2_kind;
            end
        end else if (r_out_valid && i_m_axis_tready && r_skid_valid) begin
            r_out_data <= r_skid_data;
            r_out_kind <= r_skid_kind;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_kind;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_frame_no_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == KIND_FRAME) |-> o_m_axis_tdata[143:64] == 80'd0)
        else $error("stereo frame carries fmt values");

    a_report_no_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != KIND_FRAME) |-> o_m_axis_tdata[63:0] == 64'd0)
        else $error("format report or error carries samples");
`endif

endmodule

FILE: rtl/wsts_parser.sv
// ----------------------------------------------------------------------------
// wsts_parser
// riff/wave chunk walker; one byte a cycle while enabled, registered result request
// ----------------------------------------------------------------------------
module wsts_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic          o_req_valid,
    output wsts_pkg::t_req o_req
);
    import wsts_pkg::*;

    typedef enum logic [3:0] {
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE, PH_FMT, PH_SKIP, PH_DATA, PH_IDLE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_fc, n_fc;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [32:0] r_skip, n_skip;
    logic [15:0] r_code, n_code;
    logic [15:0] r_ch, n_ch;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic        r_seen, n_seen;
    logic [31:0] r_remain, n_remain;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_lb, n_lb;
    logic [31:0] r_rb, n_rb;
    logic [4:0]  r_fidx, n_fidx;
    logic [28:0] r_frame_bytes;
    logic        r_req_valid, n_req_valid;
    t_req        r_req, n_req;

    logic        accept;
    logic [31:0] tag_in;
    logic [31:0] len_in;
    logic [32:0] padded;
    logic [12:0] bps;
    logic [31:0] bps_w;
    logic [31:0] rpos;
    logic [31:0] pos_inc;
    t_conv       mode;

    assign accept = i_en && i_valid;
    assign tag_in = {r_tag[23:0], i_byte};
    assign bps    = r_bits[15:3];
    assign bps_w  = {19'd0, bps};
    assign rpos   = r_pos - bps_w;
    assign pos_inc = r_pos + 32'd1;

    always_comb begin
        len_in = r_len;
        len_in[8*r_fc +: 8] = i_byte;
        padded = {1'b0, len_in} + {32'd0, len_in[0]};
    end

    always_comb begin
        if (r_code == CODE_FLOAT && r_bits == 16'd32) begin
            mode = CV_PASS;
        end else if (r_bits == 16'd16) begin
            mode = CV_16;
        end else if (r_bits == 16'd24) begin
            mode = CV_24;
        end else if (r_bits == 16'd32) begin
            mode = CV_32;
        end else begin
            mode = CV_ZERO;
        end
    end

    always_comb begin
        n_phase = r_phase; n_fc = r_fc; n_tag = r_tag; n_len = r_len; n_skip = r_skip;
        n_code = r_code; n_ch = r_ch; n_rate = r_rate; n_bits = r_bits; n_seen = r_seen;
        n_remain = r_remain; n_pos = r_pos; n_lb = r_lb; n_rb = r_rb; n_fidx = r_fidx;
        n_req_valid = 1'b0;
        n_req = '0;
        n_req.mode = CV_ZERO;
        n_req.format_tag = r_code;
        n_req.channel_count = r_ch;
        n_req.rate_hz = r_rate;
        n_req.bits_each = r_bits;
        case (r_phase)
            PH_RIFF, PH_WAVE, PH_CID: begin
                n_tag = tag_in;
                n_fc = r_fc + 2'd1;
                if (r_fc == 2'd3) begin
                    if (r_phase == PH_CID) begin
                        n_len = '0;
                        n_phase = PH_CSIZE;
                    end else if (tag_in == ((r_phase == PH_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
                        n_phase = (r_phase == PH_RIFF) ? PH_RSIZE : PH_CID;
                        n_tag = '0;
                    end else begin
                        n_phase = PH_IDLE;
                        n_req_valid = 1'b1;
                        n_req.kind = KIND_ERROR;
                    end
                end
            end
            PH_RSIZE: begin
                n_fc = r_fc + 2'd1;
                if (r_fc == 2'd3) begin
                    n_tag = '0;
                    n_phase = PH_WAVE;
                end
            end
            PH_CSIZE: begin
                n_len = len_in;
                n_fc = r_fc + 2'd1;
                if (r_fc == 2'd3) begin
                    if (r_tag == TAG_FMT) begin
                        n_code = '0; n_ch = '0; n_rate = '0; n_bits = '0;
                        n_seen = 1'b1;
                        n_skip = padded;
                        n_fidx = '0;
                        n_phase = (padded != 33'd0) ? PH_FMT : PH_CID;
                    end else if (r_tag == TAG_DATA) begin
                        n_req_valid = 1'b1;
                        if (!r_seen || r_ch == 16'd0 || bps == 13'd0) begin
                            n_phase = PH_IDLE;
                            n_req.kind = KIND_ERROR;
                        end else begin
                            n_remain = len_in;
                            n_pos = '0; n_lb = '0; n_rb = '0;
                            n_phase = (len_in != 32'd0) ? PH_DATA : PH_IDLE;
                            n_req.kind = KIND_FORMAT;
                        end
                    end else begin
                        n_skip = padded;
                        n_phase = (padded != 33'd0) ? PH_SKIP : PH_CID;
                    end
                end
            end
            PH_FMT: begin
                if (r_fidx < FMT_BODY && {27'd0, r_fidx} < r_len) begin
                    case (r_fidx)
                        5'd0: n_code[7:0] = i_byte;
                        5'd1: n_code[15:8] = i_byte;
                        5'd2: n_ch[7:0] = i_byte;
                        5'd3: n_ch[15:8] = i_byte;
                        5'd4: n_rate[7:0] = i_byte;
                        5'd5: n_rate[15:8] = i_byte;
                        5'd6: n_rate[23:16] = i_byte;
                        5'd7: n_rate[31:24] = i_byte;
                        5'd14: n_bits[7:0] = i_byte;
                        5'd15: n_bits[15:8] = i_byte;
                        default: ;
                    endcase
                end
                if (r_fidx < FMT_BODY) begin
                    n_fidx = r_fidx + 5'd1;
                end
                n_skip = r_skip - 33'd1;
                if (r_skip == 33'd1) begin
                    n_phase = PH_CID;
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 33'd1;
                if (r_skip == 33'd1) begin
                    n_phase = PH_CID;
                end
            end
            PH_DATA: begin
                if (r_pos < bps_w && r_pos < 32'd4) begin
                    n_lb[8*r_pos[1:0] +: 8] = i_byte;
                end
                if (r_ch >= 16'd2 && r_pos >= bps_w && rpos < bps_w && rpos < 32'd4) begin
                    n_rb[8*rpos[1:0] +: 8] = i_byte;
                end
                n_pos = pos_inc;
                if (pos_inc >= {3'd0, r_frame_bytes}) begin
                    n_req_valid = 1'b1;
                    n_req.kind = KIND_FRAME;
                    n_req.mode = mode;
                    n_req.left_raw = n_lb;
                    n_req.right_raw = (r_ch >= 16'd2) ? n_rb : n_lb;
                    n_req.format_tag = '0;
                    n_req.channel_count = '0;
                    n_req.rate_hz = '0;
                    n_req.bits_each = '0;
                    n_pos = '0; n_lb = '0; n_rb = '0;
                end
                n_remain = r_remain - 32'd1;
                if (r_remain == 32'd1) begin
                    n_phase = PH_IDLE;
                end
            end
            default: ;
        endcase
        // last byte of the file: back to the start
        if (i_last) begin
            n_phase = PH_RIFF; n_fc = '0; n_tag = '0; n_len = '0; n_skip = '0;
            n_code = '0; n_ch = '0; n_rate = '0; n_bits = '0; n_seen = 1'b0;
            n_remain = '0; n_pos = '0; n_lb = '0; n_rb = '0; n_fidx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame_bytes <= 29'(bps * r_ch);
        if (!i_rst_n) begin
            r_phase <= PH_RIFF; r_fc <= '0; r_tag <= '0; r_len <= '0; r_skip <= '0;
            r_code <= '0; r_ch <= '0; r_rate <= '0; r_bits <= '0; r_seen <= 1'b0;
            r_remain <= '0; r_pos <= '0; r_lb <= '0; r_rb <= '0; r_fidx <= '0;
            r_req_valid <= 1'b0;
        end else if (i_en) begin
            r_req_valid <= accept && n_req_valid;
            if (accept) begin
                r_phase <= n_phase; r_fc <= n_fc; r_tag <= n_tag; r_len <= n_len;
                r_skip <= n_skip; r_code <= n_code; r_ch <= n_ch; r_rate <= n_rate;
                r_bits <= n_bits; r_seen <= n_seen; r_remain <= n_remain; r_pos <= n_pos;
                r_lb <= n_lb; r_rb <= n_rb; r_fidx <= n_fidx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_req <= n_req;
        end
    end

    assign o_req_valid = r_req_valid;
    assign o_req = r_req;

endmodule

FILE: rtl/wsts_conv.sv
// ----------------------------------------------------------------------------
// wsts_conv
// one sample lane: signed pcm to ieee single or float passthrough, two register stages
// ----------------------------------------------------------------------------
module wsts_conv (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [31:0]     i_raw,
    input  wsts_pkg::t_conv i_mode,
    output logic [31:0]     o_single
);
    import wsts_pkg::*;

    // stage 1: sign and magnitude
    logic        r1_sign, r1_pass, r1_zero;
    logic [31:0] r1_mag, r1_raw;
    logic [4:0]  r1_off;
    // stage 2: leading one found
    logic        r2_sign, r2_pass, r2_zero;
    logic [31:0] r2_mag, r2_raw;
    logic [4:0]  r2_off, r2_p;

    logic [31:0] sext, mag;
    logic [4:0]  off, lead;
    logic [4:0]  sh;
    logic [32:0] shifted, rem_mask, rem, half;
    logic [24:0] mant;
    logic [5:0]  p_fin;
    logic [8:0]  bexp;

    always_comb begin
        case (i_mode)
            CV_16: begin
                sext = {{16{i_raw[15]}}, i_raw[15:0]};
                off = 5'd15;
            end
            CV_24: begin
                sext = {{8{i_raw[23]}}, i_raw[23:0]};
                off = 5'd23;
            end
            default: begin
                sext = i_raw;
                off = 5'd31;
            end
        endcase
        mag = sext[31] ? (32'd0 - sext) : sext;
    end

    always_comb begin
        lead = '0;
        for (int k = 0; k < 32; k++) begin
            if (r1_mag[k]) begin
                lead = 5'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sign <= sext[31];
            r1_mag  <= mag;
            r1_off  <= off;
            r1_raw  <= i_raw;
            r1_pass <= (i_mode == CV_PASS);
            r1_zero <= (i_mode == CV_ZERO);
            r2_sign <= r1_sign;
            r2_mag  <= r1_mag;
            r2_off  <= r1_off;
            r2_raw  <= r1_raw;
            r2_pass <= r1_pass;
            r2_zero <= r1_zero || (r1_mag == 32'd0);
            r2_p    <= lead;
        end
    end

    // normalize and round to nearest even
    always_comb begin
        sh = '0;
        shifted = '0;
        rem_mask = '0;
        rem = '0;
        half = '0;
        if (r2_p <= 5'd23) begin
            shifted = {1'b0, r2_mag} << (5'd23 - r2_p);
            mant = shifted[24:0];
        end else begin
            sh = r2_p - 5'd23;
            shifted = {1'b0, r2_mag} >> sh;
            rem_mask = (33'd1 << sh) - 33'd1;
            rem = {1'b0, r2_mag} & rem_mask;
            half = 33'd1 << (sh - 5'd1);
            mant = shifted[24:0];
            if (rem > half || (rem == half && shifted[0])) begin
                mant = mant + 25'd1;
            end
        end
        p_fin = {1'b0, r2_p};
        if (mant[24]) begin
            mant = mant >> 1;
            p_fin = p_fin + 6'd1;
        end
        bexp = {3'd0, p_fin} + 9'd127 - {4'd0, r2_off};
        if (r2_pass) begin
            o_single = r2_raw;
        end else if (r2_zero) begin
            o_single = '0;
        end else begin
            o_single = {r2_sign, bexp[7:0], mant[22:0]};
        end
    end

endmodule

FILE: tb/sv/wsts_checker.sv
// ----------------------------------------------------------------------------
// wsts_checker
// watches both stream sides of the wav decoder, predicts each result word
// from the accepted file bytes and compares its kind and whole data word
// ----------------------------------------------------------------------------
module wsts_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [7:0]   i_s_tdata,
    input  logic         i_s_tlast,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [143:0] i_m_tdata,
    input  logic [1:0]   i_m_tuser,
    output int           o_fail_count,
    output int           o_pending
);
    import wsts_pkg::*;

    typedef enum logic [3:0] {
        P_RIFF, P_RSIZE, P_WAVE, P_CID, P_CSIZE, P_FMT, P_SKIP, P_DATA, P_IDLE
    } t_phase;

    typedef struct packed {
        logic [1:0]   kind;
        logic [143:0] data;
    } t_word;

    t_phase      phase;
    logic [3:0]  fcnt;
    logic [31:0] ctag, clen, drem, fpos, lbytes, rbytes, rate;
    logic [32:0] skip;
    logic [15:0] fcode, chans, sbits;
    logic        fseen;
    t_word       expected_words[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_words.size();

    task automatic clear_parser();
        phase = P_RIFF; fcnt = 0; ctag = 0; clen = 0; skip = 0;
        fcode = 0; chans = 0; rate = 0; sbits = 0; fseen = 0;
        drem = 0; fpos = 0; lbytes = 0; rbytes = 0;
    endtask

    // signed n-bit integer scaled to -1..1 as single bits, ties to even
    function automatic logic [31:0] int_to_float(logic [31:0] raw, int n);
        logic [63:0] full, u, mag, mant, rem, half;
        logic        sgn;
        int          p, s;
        full = 64'd1 << n;
        u    = {32'd0, raw} & (full - 1);
        sgn  = u[n-1];
        mag  = sgn ? full - u : u;
        if (mag == 0) return 32'd0;
        p = 0;
        while ((mag >> (p + 1)) != 0) p++;
        if (p <= 23) begin
            mant = mag << (23 - p);
        end else begin
            s    = p - 23;
            rem  = mag & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            mant = mag >> s;
            if (rem > half || (rem == half && mant[0])) mant++;
            if (mant == (64'd1 << 24)) begin
                mant >>= 1;
                p++;
            end
        end
        return {sgn, 8'(p + 127 - (n - 1)), mant[22:0]};
    endfunction

    function automatic logic [31:0] lane_to_float(logic [31:0] b);
        if (fcode == CODE_FLOAT && sbits == 32) return b;
        if (sbits == 16) return int_to_float(b & 32'hFFFF, 16);
        if (sbits == 24) return int_to_float(b & 32'hFF_FFFF, 24);
        if (sbits == 32) return int_to_float(b, 32);
        return 32'd0;
    endfunction

    task automatic push_word(logic [1:0] kind, logic [31:0] l, logic [31:0] r, bit fmt);
        t_word w;
        w.kind = kind;
        w.data = fmt ? {sbits, rate, chans, fcode, 64'd0} : {80'd0, r, l};
        expected_words.push_back(w);
    endtask

    task automatic chunk_begin();
        logic [32:0] padded;
        padded = {1'b0, clen} + clen[0];
        if (ctag == TAG_FMT) begin
            fcode = 0; chans = 0; rate = 0; sbits = 0; fseen = 1;
            skip  = padded;
            phase = (padded != 0) ? P_FMT : P_CID;
        end else if (ctag == TAG_DATA) begin
            if (!fseen || chans == 0 || sbits < 8) begin
                phase = P_IDLE;
                push_word(KIND_ERROR, 0, 0, 1);
            end else begin
                drem = clen; fpos = 0; lbytes = 0; rbytes = 0;
                phase = (clen != 0) ? P_DATA : P_IDLE;
                push_word(KIND_FORMAT, 0, 0, 1);
            end
        end else begin
            skip  = padded;
            phase = (padded != 0) ? P_SKIP : P_CID;
        end
    endtask

    task automatic data_byte(logic [7:0] b);
        logic [31:0] bps, fbytes, pos, l;
        bps    = sbits / 8;
        fbytes = bps * chans;
        pos    = fpos;
        if (pos < bps && pos < 4) lbytes |= 32'(b) << (8 * pos);
        if (chans >= 2 && pos >= bps && pos - bps < bps && pos - bps < 4)
            rbytes |= 32'(b) << (8 * (pos - bps));
        pos++;
        if (pos >= fbytes) begin
            l = lane_to_float(lbytes);
            push_word(KIND_FRAME, l, (chans >= 2) ? lane_to_float(rbytes) : l, 0);
            pos = 0; lbytes = 0; rbytes = 0;
        end
        fpos = pos;
        drem--;
        if (drem == 0) phase = P_IDLE;
    endtask

    task automatic take_byte(logic [7:0] b, logic last);
        logic [32:0] idx;
        case (phase)
            P_RIFF, P_WAVE, P_CID: begin
                ctag = {ctag[23:0], b};
                fcnt++;
                if (fcnt >= 4) begin
                    fcnt = 0;
                    if (phase == P_CID) begin
                        clen  = 0;
                        phase = P_CSIZE;
                    end else if (ctag == ((phase == P_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
                        phase = (phase == P_RIFF) ? P_RSIZE : P_CID;
                        ctag  = 0;
                    end else begin
                        phase = P_IDLE;
                        push_word(KIND_ERROR, 0, 0, 1);
                    end
                end
            end
            P_RSIZE: begin
                fcnt++;
                if (fcnt >= 4) begin
                    fcnt = 0; ctag = 0; phase = P_WAVE;
                end
            end
            P_CSIZE: begin
                clen |= 32'(b) << (8 * fcnt[1:0]);
                fcnt++;
                if (fcnt >= 4) begin
                    fcnt = 0;
                    chunk_begin();
                end
            end
            P_FMT: begin
                idx = {1'b0, clen} + clen[0] - skip;
                if (idx < FMT_BODY && idx < clen) begin
                    if (idx < 2) fcode |= 16'(b) << (8 * idx);
                    else if (idx < 4) chans |= 16'(b) << (8 * (idx - 2));
                    else if (idx < 8) rate |= 32'(b) << (8 * (idx - 4));
                    else if (idx >= 14) sbits |= 16'(b) << (8 * (idx - 14));
                end
                skip--;
                if (skip == 0) phase = P_CID;
            end
            P_SKIP: begin
                skip--;
                if (skip == 0) phase = P_CID;
            end
            P_DATA: data_byte(b);
            default: ;
        endcase
        if (last) clear_parser();
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            clear_parser();
            expected_words.delete();
            fails <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected result word kind %0d data %h",
                                 i_m_tuser, i_m_tdata);
                    fails <= fails + 1;
                end else begin
                    w = expected_words.pop_front();
                    if (w.kind !== i_m_tuser || w.data !== i_m_tdata) begin
                        if (fails < 10)
                            $display("result mismatch: expected kind %0d data %h, got %0d %h",
                                     w.kind, w.data, i_m_tuser, i_m_tdata);
                        fails <= fails + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) take_byte(i_s_tdata, i_s_tlast);
        end
    end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// wav decoder testbench: builds directed and random wav files, sends them a
// byte at a time with random gaps and receiver stalls, checker compares
// ----------------------------------------------------------------------------
module tb;
    import wsts_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [7:0]   s_tdata = 0;
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [143:0] m_tdata;
    logic [1:0]   m_tuser;
    int           fail_count, pending;
    int           idle_cycles = 0;
    bit           hold_off = 0;
    bit           sending_done = 0;

    byte unsigned file_bytes[$];

    always #6 i_clk = ~i_clk;

    wav_stream_to_stereo_samples DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),   // byte_value
        .i_s_axis_tlast(s_tlast),   // stream_end
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata),   // left, right, format, channels, rate, bits
        .o_m_axis_tuser(m_tuser)    // result kind
    );

    wsts_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tlast(s_tlast),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // half the time no gap, else mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) m_tready <= 0;
        else m_tready <= ($urandom_range(0, 99) < 70);
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else if (!hold_off)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic put_tag(logic [31:0] t);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(t[8*i +: 8]);
    endtask

    task automatic put_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic put_rand(int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
    endtask

    // fmt chunk of a given body size; short sizes drop trailing fields
    task automatic put_fmt(int fsize, logic [15:0] code, logic [15:0] ch,
                           logic [31:0] rate, logic [15:0] bits);
        logic [127:0] body;
        body = {bits, 16'($urandom), 32'($urandom), rate, ch, code};
        put_tag(TAG_FMT);
        put_le(fsize, 4);
        for (int i = 0; i < fsize; i++)
            file_bytes.push_back(i < 16 ? body[8*i +: 8] : 8'($urandom));
        if (fsize % 2) put_rand(1);
    endtask

    // valid stays high across back-to-back words, drops only for a gap and after the last byte
    task automatic send_file();
        int n, g;
        n = file_bytes.size();
        for (int i = 0; i < n; i++) begin
            g = gap_len();
            if (g > 0) begin
                s_tvalid <= 0;
                repeat (g) @(posedge i_clk);
            end
            s_tvalid <= 1;
            s_tdata  <= file_bytes[i];
            s_tlast  <= (i == n - 1);
            @(posedge i_clk);
            while (!s_tready) @(posedge i_clk);
        end
        s_tvalid <= 0;
        file_bytes.delete();
    endtask

    task automatic n_skip();
        int len;
        len = $urandom_range(0, 7);
        put_le(len, 4);
        put_rand(len + (len % 2));
    endtask

    // mostly well-formed file with random layout and content; some get a bad tag, no fmt or a cut end
    task automatic random_file();
        int r, bits, ch, dlen;
        logic [15:0] code;
        bits = $urandom_range(0, 9) < 8 ?
               (($urandom_range(0, 2) == 0) ? 16 : ($urandom_range(0, 1) ? 24 : 32))
               : $urandom_range(0, 40);
        ch   = $urandom_range(0, 19) == 0 ? $urandom_range(0, 4) : $urandom_range(1, 2);
        code = $urandom_range(0, 1) ? 16'd1 : CODE_FLOAT;
        if ($urandom_range(0, 9) == 0) code = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 3) put_tag($urandom); else put_tag(TAG_RIFF);
        put_rand(4);
        if (r >= 3 && r < 6) put_tag($urandom); else put_tag(TAG_WAVE);
        if ($urandom_range(0, 3) == 0) begin
            put_tag($urandom); n_skip();
        end
        if ($urandom_range(0, 19) != 0)
            put_fmt($urandom_range(0, 9) == 0 ? $urandom_range(0, 21) : 16,
                    code, 16'(ch), $urandom, 16'(bits));
        if ($urandom_range(0, 4) == 0) begin
            put_tag($urandom); n_skip();
        end
        put_tag(TAG_DATA);
        dlen = $urandom_range(0, 60);
        put_le(dlen, 4);
        put_rand(dlen + $urandom_range(0, 5) * ($urandom_range(0, 1) ? 1 : -1 + 1));
        if ($urandom_range(0, 9) == 0 && file_bytes.size() > 6)
            void'(file_bytes.pop_back());
    endtask

    initial begin
        int sent;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: 16-bit stereo extremes
        put_tag(TAG_RIFF); put_le(32'hFFFF_FFFF, 4); put_tag(TAG_WAVE);
        put_fmt(16, 1, 2, 48000, 16);
        put_tag(TAG_DATA); put_le(12, 4);
        put_le(32'h8000_7FFF, 4); put_le(32'h0001_0000, 4); put_le(32'hFFFF_FFFF, 4);
        send_file();
        // 32-bit mono pcm with rounding, long fmt with pad, odd skip chunk
        put_tag(TAG_RIFF); put_rand(4); put_tag(TAG_WAVE);
        put_tag(32'h4C495354); put_le(3, 4); put_rand(4);
        put_fmt(19, 1, 1, 32'hFFFF_FFFF, 32);
        put_tag(TAG_DATA); put_le(12, 4);
        put_le(32'h8000_0000, 4); put_le(32'h7FFF_FFFF, 4); put_le(32'h0000_0181, 4);
        send_file();
        // second fmt chunk replaces float 32-bit with 24-bit three channels, partial frame, extra bytes
        put_tag(TAG_RIFF); put_rand(4); put_tag(TAG_WAVE);
        put_fmt(16, CODE_FLOAT, 2, 44100, 32);
        put_fmt(16, CODE_FLOAT, 3, 96000, 24);
        put_tag(TAG_DATA); put_le(11, 4);
        put_le(32'hFF80_0000, 4); put_le(32'h007F_FFFF, 4); put_rand(3); put_rand(4);
        send_file();
        // header errors: bad tag, data before fmt, zero channels, short fmt
        put_tag(32'h52494658); put_rand(3); send_file();
        put_tag(TAG_RIFF); put_rand(4); put_tag(TAG_WAVE); put_tag(TAG_DATA);
        put_le(4, 4); put_rand(4); send_file();
        put_tag(TAG_RIFF); put_rand(4); put_tag(TAG_WAVE);
        put_fmt(16, 1, 0, 8000, 16); put_tag(TAG_DATA); put_le(0, 4); send_file();
        put_tag(TAG_RIFF); put_rand(4); put_tag(TAG_WAVE);
        put_fmt(5, 1, 2, 8000, 16); put_tag(TAG_DATA); put_le(2, 4); put_rand(2);
        send_file();

        // long receiver hold-off while a file is sent
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                put_tag(TAG_RIFF); put_rand(4); put_tag(TAG_WAVE);
                put_fmt(16, 1, 1, 8000, 16);
                put_tag(TAG_DATA); put_le(40, 4); put_rand(40);
                send_file();
            end
        join

        sent = 0;
        while (sent < 1250) begin
            random_file();
            if ($urandom_range(0, 19) == 0) put_rand($urandom_range(1, 30));
            sent += file_bytes.size();
            send_file();
        end
        sending_done = 1;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
